/* design/au_rich_context_score_defines.svh */
// ----------------------------------------------------------------------------
// AU-rich context score: assertion macros
// Concurrent assertion wrappers clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef AU_RICH_CONTEXT_SCORE_DEFINES_SVH
`define AU_RICH_CONTEXT_SCORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define AURCS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define AURCS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define AURCS_ASSERT(name, prop, msg)
`define AURCS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

/* design/aurcs_pkg.sv */
// ----------------------------------------------------------------------------
// AU-rich context score package
// Shared constants, codes and elaboration helpers of the context score block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aurcs_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int WINDOW_LEN_DEF  = 30;

    localparam int ADDR_SPAN_W = 13;
    localparam int WEIGHT_W    = 33;
    localparam int FRAC_W      = 16;
    localparam int Q_W         = FRAC_W + 1;
    localparam int SCORE_W     = 18;
    localparam int KW          = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_U = 2'd3;

    localparam logic [1:0] SEED_8MER = 2'd0;
    localparam logic [1:0] SEED_7A1  = 2'd1;
    localparam logic [1:0] SEED_7M8  = 2'd2;
    localparam logic [1:0] SEED_NONE = 2'd3;

    localparam logic [1:0] ST_SCORED = 2'd0;
    localparam logic [1:0] ST_INEFF  = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic signed [SCORE_W-1:0] SCORE_INEFF = 18'sh30000;

    // Highest shift k for which depth << k still fits an unreduced address.
    function automatic int red_top(input int depth);
        int k;
        k = 0;
        while ((depth << (k + 1)) < (1 << ADDR_SPAN_W)) begin
            k = k + 1;
        end
        return k;
    endfunction

endpackage

/* design/au_rich_context_score.sv */
// A write item holds busy through R address reduction steps (1 by default) and then the store write.
// A scored site holds busy while each non-empty window, upstream first, takes R reduction steps
// and then its scan, followed by the finish and divider setup states and the divider; o_strobe
// rises as busy drops. One stored base is read per cycle and the divider retires one bit
// per cycle. Ineffective and empty sites strobe in the cycle after acceptance without busy.
// Synchronous active-low reset clears the sequencer; the store is not cleared.
// ----------------------------------------------------------------------------
// AU-rich context score
// Nucleotide store with a sequenced window scan and a serial restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "au_rich_context_score_defines.svh"

module au_rich_context_score #(
    parameter int STORE_DEPTH = aurcs_pkg::STORE_DEPTH_DEF,
    parameter int WINDOW_LEN  = aurcs_pkg::WINDOW_LEN_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_opcode,
    input  logic [11:0]                          i_write_address,
    input  logic [1:0]                           i_nucleotide,
    input  logic [11:0]                          i_site_position,
    input  logic [1:0]                           i_seed_kind,
    input  logic [12:0]                          i_sequence_length,
    input  logic                                 i_site_effective,
    output logic                                 o_strobe,
    output logic signed [aurcs_pkg::SCORE_W-1:0] o_au_score,
    output logic [1:0]                           o_status
);

    localparam int AW      = $clog2(STORE_DEPTH);
    localparam int RED_W   = (AW + 1 > aurcs_pkg::ADDR_SPAN_W) ? AW + 1 : aurcs_pkg::ADDR_SPAN_W;
    localparam int RED_TOP = aurcs_pkg::red_top(STORE_DEPTH);
    localparam int LW      = $clog2(WINDOW_LEN + 1);
    localparam int DW      = $clog2(WINDOW_LEN + 2);
    localparam int SUM_W   = aurcs_pkg::WEIGHT_W + $clog2(2 * WINDOW_LEN);
    localparam int NW      = SUM_W + aurcs_pkg::Q_W;
    localparam int QW      = aurcs_pkg::Q_W;
    localparam int KW      = aurcs_pkg::KW;
    localparam int WW      = aurcs_pkg::WEIGHT_W;
    localparam logic [RED_W-1:0] DEP      = RED_W'(STORE_DEPTH);
    localparam logic [RED_W-1:0] DEP_LAST = RED_W'(STORE_DEPTH - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_REDW  = 10'b00_0000_0010,
        S_WR    = 10'b00_0000_0100,
        S_REDU  = 10'b00_0000_1000,
        S_SCANU = 10'b00_0001_0000,
        S_REDD  = 10'b00_0010_0000,
        S_SCAND = 10'b00_0100_0000,
        S_FIN   = 10'b00_1000_0000,
        S_DSET  = 10'b01_0000_0000,
        S_DIV   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic r_strobe, n_strobe;
    logic r_pv, n_pv;
    logic signed [aurcs_pkg::SCORE_W-1:0] r_score, n_score;
    logic [1:0] r_status, n_status;
    logic [RED_W-1:0] r_addr, n_addr;
    logic [KW-1:0] r_k, n_k;
    logic [1:0] r_nuc, n_nuc;
    logic [1:0] r_kind, n_kind;
    logic [LW-1:0] r_up_len, n_up_len;
    logic [LW-1:0] r_dn_len, n_dn_len;
    logic [12:0] r_dn_start, n_dn_start;
    logic [LW-1:0] r_i, n_i;
    logic [WW-1:0] r_pw, n_pw;
    logic [1:0] r_rd_base;
    logic [SUM_W-1:0] r_au, n_au;
    logic [SUM_W-1:0] r_tot, n_tot;
    logic [SUM_W-1:0] r_rem, n_rem;
    logic [QW-1:0] r_nlo, n_nlo;

    logic [1:0] mem [0:STORE_DEPTH-1];
    logic [WW-1:0] w_tab [1:WINDOW_LEN+1];

    logic [11:0] c_pm1;
    logic [LW-1:0] c_up_len;
    logic [12:0] c_dn_start;
    logic [12:0] c_dn_room;
    logic [LW-1:0] c_dn_len;
    logic [RED_W-1:0] c_red_div;
    logic c_red_ge;
    logic [RED_W-1:0] c_red_res;
    logic [RED_W-1:0] c_addr_dec;
    logic [RED_W-1:0] c_addr_inc;
    logic [DW-1:0] c_d_up;
    logic [DW-1:0] c_d_dn;
    logic c_is_au;
    logic [SUM_W:0] c_trial;
    logic c_fit;
    logic [SUM_W:0] c_diff;
    logic [QW-1:0] c_q;
    logic [NW-1:0] c_num;

    // Weight table: round(2^32 / d) for every denominator that a scan can use.
    for (genvar g = 1; g <= WINDOW_LEN + 1; g++) begin : g_wt
        localparam longint unsigned WVAL = ((64'd1 << 32) + longint'(g / 2)) / longint'(g);
        assign w_tab[g] = WW'(WVAL);
    end

    assign c_pm1      = i_site_position - 12'd1;
    assign c_up_len   = (i_site_position == 12'd0) ? '0 :
                        (int'(c_pm1) > WINDOW_LEN) ? LW'(WINDOW_LEN) : LW'(c_pm1);
    assign c_dn_start = {1'b0, i_site_position} +
                        ((i_seed_kind == aurcs_pkg::SEED_7A1) ? 13'd7 : 13'd6);
    assign c_dn_room  = i_sequence_length - c_dn_start;
    assign c_dn_len   = (i_sequence_length <= c_dn_start) ? '0 :
                        (int'(c_dn_room) > WINDOW_LEN) ? LW'(WINDOW_LEN) : LW'(c_dn_room);

    assign c_red_div = DEP << r_k;
    assign c_red_ge  = (r_addr >= c_red_div);
    assign c_red_res = c_red_ge ? (r_addr - c_red_div) : r_addr;

    assign c_addr_dec = (r_addr[AW-1:0] == '0) ? DEP_LAST : (r_addr - RED_W'(1));
    assign c_addr_inc = (r_addr == DEP_LAST) ? '0 : (r_addr + RED_W'(1));

    assign c_d_up = (r_kind == aurcs_pkg::SEED_7A1) ? (DW'(r_i) + DW'(2)) : (DW'(r_i) + DW'(1));
    assign c_d_dn = (r_kind != aurcs_pkg::SEED_7M8) ? (DW'(r_i) + DW'(2)) :
                    (r_i == '0) ? DW'(2) : (DW'(r_i) + DW'(1));

    assign c_is_au = (r_rd_base == aurcs_pkg::BASE_A) || (r_rd_base == aurcs_pkg::BASE_U);

    assign c_trial = {r_rem, r_nlo[QW-1]};
    assign c_fit   = (c_trial >= {1'b0, r_tot});
    assign c_diff  = c_trial - {1'b0, r_tot};
    assign c_q     = {r_nlo[QW-2:0], c_fit};
    assign c_num   = NW'({r_au, {aurcs_pkg::FRAC_W{1'b0}}}) + NW'(r_tot >> 1);

    always_comb begin
        n_state    = r_state;
        n_strobe   = 1'b0;
        n_pv       = 1'b0;
        n_score    = r_score;
        n_status   = r_status;
        n_addr     = r_addr;
        n_k        = r_k;
        n_nuc      = r_nuc;
        n_kind     = r_kind;
        n_up_len   = r_up_len;
        n_dn_len   = r_dn_len;
        n_dn_start = r_dn_start;
        n_i        = r_i;
        n_pw       = r_pw;
        n_au       = r_au;
        n_tot      = r_tot;
        n_rem      = r_rem;
        n_nlo      = r_nlo;

        // Accumulate the base read in the previous cycle.
        if (r_pv) begin
            n_tot = r_tot + SUM_W'(r_pw);
            if (c_is_au) begin
                n_au = r_au + SUM_W'(r_pw);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_k = KW'(RED_TOP);
                    if (i_opcode == aurcs_pkg::OP_WRITE) begin
                        n_addr  = RED_W'(i_write_address);
                        n_nuc   = i_nucleotide;
                        n_state = S_REDW;
                    end else if (!i_site_effective) begin
                        n_strobe = 1'b1;
                        n_score  = aurcs_pkg::SCORE_INEFF;
                        n_status = aurcs_pkg::ST_INEFF;
                    end else if ((i_seed_kind == aurcs_pkg::SEED_NONE) ||
                                 ((c_up_len == '0) && (c_dn_len == '0))) begin
                        n_strobe = 1'b1;
                        n_score  = '0;
                        n_status = aurcs_pkg::ST_EMPTY;
                    end else begin
                        n_kind     = i_seed_kind;
                        n_up_len   = c_up_len;
                        n_dn_len   = c_dn_len;
                        n_dn_start = c_dn_start;
                        n_i        = '0;
                        n_au       = '0;
                        n_tot      = '0;
                        if (c_up_len != '0) begin
                            n_addr  = RED_W'(i_site_position) - RED_W'(2);
                            n_state = S_REDU;
                        end else begin
                            n_addr  = RED_W'(c_dn_start);
                            n_state = S_REDD;
                        end
                    end
                end
            end
            S_REDW, S_REDU, S_REDD: begin
                n_addr = c_red_res;
                n_k    = r_k - KW'(1);
                if (r_k == '0) begin
                    if (r_state == S_REDW) begin
                        n_state = S_WR;
                    end else if (r_state == S_REDU) begin
                        n_state = S_SCANU;
                    end else begin
                        n_state = S_SCAND;
                    end
                end
            end
            S_WR: begin
                n_state = S_IDLE;
            end
            S_SCANU: begin
                n_pv   = 1'b1;
                n_pw   = w_tab[c_d_up];
                n_addr = c_addr_dec;
                n_i    = r_i + LW'(1);
                if (r_i == r_up_len - LW'(1)) begin
                    n_i = '0;
                    if (r_dn_len != '0) begin
                        n_addr  = RED_W'(r_dn_start);
                        n_k     = KW'(RED_TOP);
                        n_state = S_REDD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAND: begin
                n_pv   = 1'b1;
                n_pw   = w_tab[c_d_dn];
                n_addr = c_addr_inc;
                n_i    = r_i + LW'(1);
                if (r_i == r_dn_len - LW'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_DSET;
            end
            S_DSET: begin
                n_rem   = c_num[NW-1:QW];
                n_nlo   = c_num[QW-1:0];
                n_k     = KW'(QW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = c_fit ? c_diff[SUM_W-1:0] : c_trial[SUM_W-1:0];
                n_nlo = c_q;
                n_k   = r_k - KW'(1);
                if (r_k == '0) begin
                    n_strobe = 1'b1;
                    n_score  = {1'b0, c_q};
                    n_status = aurcs_pkg::ST_SCORED;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pv     <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_score    <= n_score;
        r_status   <= n_status;
        r_addr     <= n_addr;
        r_k        <= n_k;
        r_nuc      <= n_nuc;
        r_kind     <= n_kind;
        r_up_len   <= n_up_len;
        r_dn_len   <= n_dn_len;
        r_dn_start <= n_dn_start;
        r_i        <= n_i;
        r_pw       <= n_pw;
        r_au       <= n_au;
        r_tot      <= n_tot;
        r_rem      <= n_rem;
        r_nlo      <= n_nlo;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            mem[r_addr[AW-1:0]] <= r_nuc;
        end
        r_rd_base <= mem[r_addr[AW-1:0]];
    end

    assign busy       = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_au_score = r_score;
    assign o_status   = r_status;

    `AURCS_ASSERT(a_strobe_idle, o_strobe |-> !busy, "Result strobed while an item is still in progress.")
    `AURCS_ASSERT(a_ineff_value, (o_strobe && (o_status == aurcs_pkg::ST_INEFF)) |-> (o_au_score == aurcs_pkg::SCORE_INEFF), "Ineffective site returned a wrong score.")
    `AURCS_ASSERT(a_ratio_range, (o_strobe && (o_status == aurcs_pkg::ST_SCORED)) |-> (!o_au_score[aurcs_pkg::SCORE_W-1] && (o_au_score <= 18'sd65536)), "Scored ratio lies outside the unit range.")
    `AURCS_ASSERT(a_ineff_fast, (start && !busy && (i_opcode == aurcs_pkg::OP_SCORE) && !i_site_effective) |=> (o_strobe && (o_status == aurcs_pkg::ST_INEFF)), "Ineffective site did not answer in the next cycle.")

endmodule

/* tb/sv/au_rich_context_score_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AU-rich context score testbench
// Sends nucleotide writes and site queries through the start/busy handshake.
// A private copy of the store predicts query scores and status unless a directed
// row gives its own; every strobed result is checked in order against these.
// ----------------------------------------------------------------------------

module au_rich_context_score_tb;
    import aurcs_pkg::*;

    localparam int DEPTH        = STORE_DEPTH_DEF;
    localparam int WIN          = WINDOW_LEN_DEF;
    localparam int RANDOM_ITEMS = 1350;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PAUSE_EVERY  = 450;

    localparam logic signed [SCORE_W-1:0] SCORE_ONE  = 18'sd65536;
    localparam logic signed [SCORE_W-1:0] SCORE_ZERO = 18'sd0;
    localparam longint unsigned           Q32_ONE    = 64'h1_0000_0000;

    typedef struct packed {
        logic        op;
        logic [11:0] waddr;
        logic [1:0]  nuc;
        logic [11:0] pos;
        logic [1:0]  kind;
        logic [12:0] len;
        logic        eff;
    } site_item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [1:0]                status;
    } au_result_t;

    typedef struct packed {
        site_item_t item;
        bit         use_typed;
        au_result_t want;
    } dir_row_t;

    logic                       i_clk             = 1'b0;
    logic                       i_rst_n           = 1'b0;
    logic                       start             = 1'b0;
    logic                       busy;
    logic                       i_opcode          = OP_WRITE;
    logic [11:0]                i_write_address   = '0;
    logic [1:0]                 i_nucleotide      = '0;
    logic [11:0]                i_site_position   = '0;
    logic [1:0]                 i_seed_kind       = SEED_8MER;
    logic [12:0]                i_sequence_length = '0;
    logic                       i_site_effective  = 1'b0;
    logic                       o_strobe;
    logic signed [SCORE_W-1:0]  o_au_score;
    logic [1:0]                 o_status;

    logic [1:0]   base_model [DEPTH];
    bit           base_known [DEPTH];
    au_result_t   expected_scores [$];
    dir_row_t     directed [$];

    int mismatch_count = 0;
    int writes_done    = 0;
    int queries_done   = 0;
    int n_scored       = 0;
    int n_ineff        = 0;
    int n_empty        = 0;
    int n_wrapped      = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int stretch_left   = 0;
    bit stretch_quiet  = 1'b0;

    au_rich_context_score i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_write_address   (i_write_address),
        .i_nucleotide      (i_nucleotide),
        .i_site_position   (i_site_position),
        .i_seed_kind       (i_seed_kind),
        .i_sequence_length (i_sequence_length),
        .i_site_effective  (i_site_effective),
        .o_strobe          (o_strobe),
        .o_au_score        (o_au_score),
        .o_status          (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_scores.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int unsigned weight_den(input logic [1:0] kind, input bit upstream,
                                               input int unsigned step);
        case (kind)
            SEED_8MER: return upstream ? step + 1 : step + 2;
            SEED_7A1:  return step + 2;
            SEED_7M8:  return (upstream || step != 0) ? step + 1 : 2;
            default:   return 0;
        endcase
    endfunction

    function automatic au_result_t predict_au_ratio(input site_item_t it);
        longint unsigned au_sum, all_sum, w, q;
        int unsigned     up_lo, n_up, dn_lo, dn_hi, n_dn, d, a, step, i;
        bit              upstream;
        logic [1:0]      b;
        au_result_t      r;
        au_sum  = 0;
        all_sum = 0;
        if (!it.eff) begin
            r.score  = SCORE_INEFF;
            r.status = ST_INEFF;
            return r;
        end
        up_lo = (it.pos > WIN + 1) ? it.pos - (WIN + 1) : 0;
        n_up  = (it.pos >= up_lo + 1) ? it.pos - 1 - up_lo : 0;
        dn_lo = it.pos + ((it.kind == SEED_7A1) ? 7 : 6);
        dn_hi = (it.len < dn_lo + WIN) ? it.len : dn_lo + WIN;
        n_dn  = (dn_hi > dn_lo) ? dn_hi - dn_lo : 0;
        for (i = 0; i < n_up + n_dn; i++) begin
            upstream = (i < n_up);
            step     = upstream ? i : i - n_up;
            a        = upstream ? it.pos - 2 - step : dn_lo + step;
            d        = weight_den(it.kind, upstream, step);
            if (d != 0) begin
                w = (Q32_ONE + d / 2) / d;
                b = base_model[a % DEPTH];
                if (b == BASE_A || b == BASE_U) begin
                    au_sum += w;
                end
                all_sum += w;
            end
        end
        if (all_sum == 0) begin
            r.score  = SCORE_ZERO;
            r.status = ST_EMPTY;
        end else begin
            q        = ((au_sum << 16) + all_sum / 2) / all_sum;
            r.score  = q[SCORE_W-1:0];
            r.status = ST_SCORED;
        end
        return r;
    endfunction

    task automatic send_item(input site_item_t it, input bit use_typed, input au_result_t want);
        int gap;
        if (stretch_left == 0) begin
            stretch_left  = $urandom_range(20, 80);
            stretch_quiet = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        gap = stretch_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_opcode          <= it.op;
        i_write_address   <= it.waddr;
        i_nucleotide      <= it.nuc;
        i_site_position   <= it.pos;
        i_seed_kind       <= it.kind;
        i_sequence_length <= it.len;
        i_site_effective  <= it.eff;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        if (it.op == OP_WRITE) begin
            base_model[it.waddr] = it.nuc;
            base_known[it.waddr] = 1'b1;
            writes_done++;
        end else begin
            expected_scores.push_back(use_typed ? want : predict_au_ratio(it));
            queries_done++;
        end
    endtask

    // Every base that a query may read is written first, with random content.
    task automatic fill_site_window(input logic [11:0] pos, input logic [12:0] len);
        int unsigned lo, hi, a;
        site_item_t  w;
        au_result_t  none;
        none = '0;
        w    = '0;
        w.op = OP_WRITE;
        lo   = (pos > WIN + 1) ? pos - (WIN + 1) : 0;
        hi   = (len < pos + 7 + WIN) ? len : pos + 7 + WIN;
        for (a = lo; a + 2 <= pos; a++) begin
            if (!base_known[a % DEPTH]) begin
                w.waddr = 12'(a % DEPTH);
                w.nuc   = 2'($urandom_range(0, 3));
                send_item(w, 1'b0, none);
            end
        end
        for (a = pos + 6; a < hi; a++) begin
            if (!base_known[a % DEPTH]) begin
                w.waddr = 12'(a % DEPTH);
                w.nuc   = 2'($urandom_range(0, 3));
                send_item(w, 1'b0, none);
            end
        end
    endtask

    function automatic dir_row_t dir_write(input int addr, input logic [1:0] nuc);
        dir_row_t r;
        r            = '0;
        r.item.op    = OP_WRITE;
        r.item.waddr = 12'(addr);
        r.item.nuc   = nuc;
        return r;
    endfunction

    function automatic dir_row_t dir_score(input int pos, input logic [1:0] kind, input int len,
                                           input logic eff, input bit use_typed,
                                           input logic signed [SCORE_W-1:0] score,
                                           input logic [1:0] status);
        dir_row_t r;
        r             = '0;
        r.item.op     = OP_SCORE;
        r.item.pos    = 12'(pos);
        r.item.kind   = kind;
        r.item.len    = 13'(len);
        r.item.eff    = eff;
        r.use_typed   = use_typed;
        r.want.score  = score;
        r.want.status = status;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        au_result_t want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_scores.size() == 0) begin
                report_mismatch("result strobed with no query outstanding");
            end else begin
                want = expected_scores.pop_front();
                if (o_au_score !== want.score) begin
                    report_mismatch($sformatf("au_score %0d, predicted %0d",
                                              o_au_score, want.score));
                end
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              o_status, want.status));
                end
                case (want.status)
                    ST_SCORED: n_scored++;
                    ST_INEFF:  n_ineff++;
                    default:   n_empty++;
                endcase
            end
        end
    end

    initial begin : stimulus
        site_item_t it;
        au_result_t none;
        int         pick, zone, lsel, next_pause;
        none       = '0;
        next_pause = PAUSE_EVERY;

        // Reads stay within bases that earlier rows have written.
        directed.push_back(dir_score(0, SEED_8MER, 0, 1'b1, 1'b1, SCORE_ZERO, ST_EMPTY));
        directed.push_back(dir_score(4095, SEED_7M8, 8191, 1'b0, 1'b1, SCORE_INEFF, ST_INEFF));
        directed.push_back(dir_score(0, SEED_NONE, 0, 1'b0, 1'b1, SCORE_INEFF, ST_INEFF));
        directed.push_back(dir_score(1, SEED_NONE, 7, 1'b1, 1'b1, SCORE_ZERO, ST_EMPTY));
        directed.push_back(dir_score(1, SEED_7A1, 8, 1'b1, 1'b1, SCORE_ZERO, ST_EMPTY));
        directed.push_back(dir_write(0, BASE_U));
        directed.push_back(dir_write(8, BASE_A));
        directed.push_back(dir_write(9, BASE_U));
        directed.push_back(dir_write(4095, BASE_U));
        directed.push_back(dir_score(2, SEED_8MER, 9, 1'b1, 1'b1, SCORE_ONE, ST_SCORED));
        directed.push_back(dir_score(2, SEED_7A1, 10, 1'b1, 1'b1, SCORE_ONE, ST_SCORED));
        directed.push_back(dir_score(2, SEED_7M8, 9, 1'b1, 1'b1, SCORE_ONE, ST_SCORED));
        directed.push_back(dir_score(2, SEED_NONE, 9, 1'b1, 1'b1, SCORE_ZERO, ST_EMPTY));
        directed.push_back(dir_write(0, 2'd1));
        directed.push_back(dir_write(8, 2'd2));
        directed.push_back(dir_write(9, 2'd2));
        directed.push_back(dir_score(2, SEED_8MER, 10, 1'b1, 1'b1, SCORE_ZERO, ST_SCORED));
        directed.push_back(dir_write(8, BASE_U));
        directed.push_back(dir_score(2, SEED_8MER, 9, 1'b1, 1'b0, SCORE_ZERO, ST_SCORED));
        directed.push_back(dir_score(2, SEED_7M8, 10, 1'b1, 1'b0, SCORE_ZERO, ST_SCORED));
        directed.push_back(dir_score(2, SEED_7A1, 10, 1'b1, 1'b0, SCORE_ZERO, ST_SCORED));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_item(directed[k].item, directed[k].use_typed, directed[k].want);
        end

        while (items_sent < directed.size() + RANDOM_ITEMS) begin
            if (items_sent >= next_pause) begin
                next_pause += PAUSE_EVERY;
                start <= 1'b0;
                do @(posedge i_clk); while (expected_scores.size() != 0);
            end
            it       = '0;
            it.waddr = 12'($urandom_range(0, 4095));
            it.nuc   = 2'($urandom_range(0, 3));
            pick     = $urandom_range(0, 99);
            if (pick < 15) begin
                it.op = OP_WRITE;
            end else if (pick < 25) begin
                it.op   = OP_SCORE;
                it.pos  = 12'($urandom_range(0, 4095));
                it.kind = 2'($urandom_range(0, 3));
                it.len  = 13'($urandom_range(0, 8191));
                it.eff  = 1'b0;
            end else begin
                it.op   = OP_SCORE;
                it.eff  = 1'b1;
                it.kind = 2'($urandom_range(0, 3));
                zone    = $urandom_range(0, 99);
                if (zone < 45) begin
                    it.pos = 12'($urandom_range(0, 159));
                end else if (zone < 97) begin
                    it.pos = 12'($urandom_range(3936, 4095));
                end else begin
                    it.pos = 12'($urandom_range(0, 4095));
                end
                lsel = $urandom_range(0, 9);
                if (lsel < 3) begin
                    it.len = 13'(it.pos + $urandom_range(0, 45));
                end else if (lsel < 5) begin
                    it.len = 13'($urandom_range(0, 63));
                end else if (lsel < 7) begin
                    it.len = 13'($urandom_range(0, 8191));
                end else begin
                    it.len = 13'(it.pos + $urandom_range(36, 60));
                end
                fill_site_window(it.pos, it.len);
                if (it.len > DEPTH && it.pos + 6 + WIN > DEPTH) begin
                    n_wrapped++;
                end
            end
            send_item(it, 1'b0, none);
        end

        start <= 1'b0;
        do @(posedge i_clk); while (expected_scores.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d nucleotide writes and %0d site queries: %0d scored, %0d ineffective,",
                 writes_done, queries_done, n_scored, n_ineff);
        $display("%0d with empty windows, %0d wrapping past the top of the store; %0d mismatches.",
                 n_empty, n_wrapped, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
